@@ src/fresnel_dielectric_reflectance_top_assert.svh @@
// Assertion macros shared by the Fresnel reflectance block.
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_TOP_ASSERT_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_TOP_ASSERT_SVH

// Same-cycle implication, reset masks the check
`define FDR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fdr: same-cycle check failed");

// Next-cycle implication, reset masks the check
`define FDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fdr: next-cycle check failed");

`endif

@@ src/fdr_pkg.sv @@
package fdr_pkg;

  localparam int unsigned EtaW = 16;
  localparam int unsigned CosW = 16;
  localparam int unsigned MagW = 15;   // |cos|, sines and cosines, Q1.14 up to 1.0
  localparam int unsigned RefW = 16;

  localparam logic [EtaW-1:0] EtaOutsideRst = 16'd4096;
  localparam logic [EtaW-1:0] EtaInsideRst  = 16'd6144;

  localparam logic signed [CosW-1:0] CosMax = 16'sd16384;
  localparam logic signed [CosW-1:0] CosMin = -16'sd16384;
  localparam logic [RefW-1:0]        OneQ15 = 16'h8000;
  localparam logic [29:0]            OneSqQ28 = 30'h1000_0000;

  // Register indexes
  typedef enum logic [0:0] {
    CFG_ETA_OUTSIDE = 1'b0,
    CFG_ETA_INSIDE  = 1'b1
  } cfg_idx_e;

  // Sideband carried through the first square root
  typedef struct packed {
    logic [EtaW-1:0] ei;
    logic [EtaW-1:0] et;
    logic [MagW-1:0] c;
  } geo_sb_t;

  // Sideband carried through the sine divider and second square root
  typedef struct packed {
    logic            tir;
    logic [EtaW-1:0] ei;
    logic [EtaW-1:0] et;
    logic [MagW-1:0] c;
  } tir_sb_t;

  // Sideband of the parallel ratio divider
  typedef struct packed {
    logic tir;
    logic eq;
  } rat_sb_t;

endpackage

@@ src/fresnel_dielectric_reflectance_top.sv @@
// Unpolarized Fresnel reflectance of a dielectric interface.
// Input stream: one signed Q1.14 incident cosine per transaction on s_axis.
// Output stream: one transaction per input on m_axis: reflectance in unsigned
// Q1.15 on tdata, total internal reflection flag on tuser.
// Indices eta_outside (index 0) and eta_inside (index 1) are Q4.12 registers
// written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them
// only while the stream is idle, as the block itself does not enforce this.
// Throughput: one transaction per cycle while the receiver does not stall.
// The chain: two 15-stage square roots, a 14-stage transmitted-sine divider and
// two parallel 15-stage ratio dividers, with multiply and combine stages between.
// Reset clears all valid bits and loads eta_outside = 1.0, eta_inside = 1.5.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_axis_tready_o drops; nothing is lost or repeated, and the pipeline moves
// again on the cycle tready returns.
`include "fresnel_dielectric_reflectance_top_assert.svh"
module fresnel_dielectric_reflectance_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] cos_incident
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] reflectance
  output logic [0:0]  m_axis_tuser_o,   // [0] total_internal
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned EW = fdr_pkg::EtaW;
  localparam int unsigned MW = fdr_pkg::MagW;

  logic en;

  // Configuration registers
  logic [EW-1:0] eta_out_q, eta_in_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_out_q <= fdr_pkg::EtaOutsideRst;
      eta_in_q  <= fdr_pkg::EtaInsideRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fdr_pkg::CFG_ETA_OUTSIDE) eta_out_q <= cfg_data_i;
      if (cfg_idx_i == fdr_pkg::CFG_ETA_INSIDE)  eta_in_q  <= cfg_data_i;
    end
  end

  // Global advance: move whenever the output slot is free or being taken
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Stage A: clamp, direction, index swap
  logic signed [15:0] cs_raw, cs_cl, cs_neg;
  logic               entering;
  fdr_pkg::geo_sb_t   a_d, a_q;
  logic               vld_a_q;
  always_comb begin
    cs_raw = $signed(s_axis_tdata_i);
    cs_cl  = cs_raw;
    if (cs_raw > fdr_pkg::CosMax) cs_cl = fdr_pkg::CosMax;
    if (cs_raw < fdr_pkg::CosMin) cs_cl = fdr_pkg::CosMin;
    cs_neg   = -cs_cl;
    entering = (cs_cl > 16'sd0);
    a_d.c    = cs_cl[15] ? cs_neg[MW-1:0] : cs_cl[MW-1:0];
    a_d.ei   = entering ? eta_out_q : eta_in_q;
    a_d.et   = entering ? eta_in_q  : eta_out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_a_q <= 1'b0;
    else if (en) vld_a_q <= s_axis_tvalid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) a_q <= a_d;
  end

  // Stage B: 1 - c^2
  logic [29:0]      cc, v1_b_q;
  fdr_pkg::geo_sb_t b_q;
  logic             vld_b_q;
  assign cc = {15'd0, a_q.c} * {15'd0, a_q.c};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_b_q <= 1'b0;
    else if (en) vld_b_q <= vld_a_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      v1_b_q <= fdr_pkg::OneSqQ28 - cc;
      b_q    <= a_q;
    end
  end

  // Incident sine
  logic             vld_s1;
  logic [MW-1:0]    si;
  fdr_pkg::geo_sb_t s1_sb;
  fdr_sqrt #(.VW(30), .SB_W($bits(fdr_pkg::geo_sb_t))) u_sqrt_si (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(vld_b_q), .v_i(v1_b_q), .sb_i(b_q),
    .vld_o(vld_s1), .root_o(si), .sb_o(s1_sb)
  );

  // Stage C: ei * si
  logic [30:0]      n_c_q;
  fdr_pkg::geo_sb_t c_q;
  logic             vld_c_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_c_q <= 1'b0;
    else if (en) vld_c_q <= vld_s1;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      n_c_q <= {15'd0, s1_sb.ei} * {16'd0, si};
      c_q   <= s1_sb;
    end
  end

  // TIR check: quotient would reach 1.0 (also catches a zero index)
  fdr_pkg::tir_sb_t dv_sb;
  logic [EW-1:0]    dv_r0;
  always_comb begin
    dv_sb.tir = (n_c_q[30:14] >= {1'b0, c_q.et});
    dv_sb.ei  = c_q.ei;
    dv_sb.et  = c_q.et;
    dv_sb.c   = c_q.c;
    dv_r0     = dv_sb.tir ? '0 : n_c_q[29:14];
  end

  // Transmitted sine
  logic             vld_st;
  logic [13:0]      st;
  fdr_pkg::tir_sb_t st_sb;
  fdr_div #(.DW(EW), .QW(14), .SB_W($bits(fdr_pkg::tir_sb_t))) u_div_st (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(vld_c_q), .r0_i(dv_r0), .lo_i(n_c_q[13:0]), .den_i(c_q.et), .sb_i(dv_sb),
    .vld_o(vld_st), .quo_o(st), .sb_o(st_sb)
  );

  // Stage E: 1 - st^2
  logic [27:0]      stst;
  logic [29:0]      v2_e_q;
  fdr_pkg::tir_sb_t e_q;
  logic             vld_e_q;
  assign stst = {14'd0, st} * {14'd0, st};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_e_q <= 1'b0;
    else if (en) vld_e_q <= vld_st;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      v2_e_q <= fdr_pkg::OneSqQ28 - {2'b00, stst};
      e_q    <= st_sb;
    end
  end

  // Transmitted cosine
  logic             vld_s2;
  logic [MW-1:0]    ct;
  fdr_pkg::tir_sb_t s2_sb;
  fdr_sqrt #(.VW(30), .SB_W($bits(fdr_pkg::tir_sb_t))) u_sqrt_ct (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(vld_e_q), .v_i(v2_e_q), .sb_i(e_q),
    .vld_o(vld_s2), .root_o(ct), .sb_o(s2_sb)
  );

  // Stage F: the four cross products
  logic [30:0] pa_q, pb_q, pd_q, pe_q;
  logic        tir_f_q, vld_f_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_f_q <= 1'b0;
    else if (en) vld_f_q <= vld_s2;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q    <= {15'd0, s2_sb.et} * {16'd0, s2_sb.c};
      pb_q    <= {15'd0, s2_sb.ei} * {16'd0, ct};
      pd_q    <= {15'd0, s2_sb.ei} * {16'd0, s2_sb.c};
      pe_q    <= {15'd0, s2_sb.et} * {16'd0, ct};
      tir_f_q <= s2_sb.tir;
    end
  end

  // Stage G: sums, differences, equal-case flags
  logic [31:0] den_p_d, den_q_d, abs_p, abs_q;
  logic [31:0] den_p_q, den_q_q, r0_p_q, r0_q_q;
  logic        eq_p_q, eq_q_q, tir_g_q, vld_g_q;
  always_comb begin
    den_p_d = {1'b0, pa_q} + {1'b0, pb_q};
    den_q_d = {1'b0, pd_q} + {1'b0, pe_q};
    abs_p   = (pa_q >= pb_q) ? {1'b0, pa_q - pb_q} : {1'b0, pb_q - pa_q};
    abs_q   = (pd_q >= pe_q) ? {1'b0, pd_q - pe_q} : {1'b0, pe_q - pd_q};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_g_q <= 1'b0;
    else if (en) vld_g_q <= vld_f_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      den_p_q <= den_p_d;
      den_q_q <= den_q_d;
      eq_p_q  <= (abs_p == den_p_d);
      eq_q_q  <= (abs_q == den_q_d);
      r0_p_q  <= (abs_p == den_p_d) ? '0 : abs_p;
      r0_q_q  <= (abs_q == den_q_d) ? '0 : abs_q;
      tir_g_q <= tir_f_q;
    end
  end

  // Amplitude ratios in Q1.15
  fdr_pkg::rat_sb_t rp_in, rp_sb;
  logic             vld_rp, vld_rq, rq_eq;
  logic [14:0]      qp, qq;
  assign rp_in.tir = tir_g_q;
  assign rp_in.eq  = eq_p_q;
  fdr_div #(.DW(32), .QW(15), .SB_W($bits(fdr_pkg::rat_sb_t))) u_div_p (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(vld_g_q), .r0_i(r0_p_q), .lo_i('0), .den_i(den_p_q), .sb_i(rp_in),
    .vld_o(vld_rp), .quo_o(qp), .sb_o(rp_sb)
  );
  fdr_div #(.DW(32), .QW(15), .SB_W(1)) u_div_q (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(vld_g_q), .r0_i(r0_q_q), .lo_i('0), .den_i(den_q_q), .sb_i(eq_q_q),
    .vld_o(vld_rq), .quo_o(qq), .sb_o(rq_eq)
  );

  // Stage H: squares
  logic [15:0] rp, rq;
  logic [31:0] pp_q, qq_q;
  logic        tir_h_q, vld_h_q;
  assign rp = rp_sb.eq ? fdr_pkg::OneQ15 : {1'b0, qp};
  assign rq = rq_eq    ? fdr_pkg::OneQ15 : {1'b0, qq};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_h_q <= 1'b0;
    else if (en) vld_h_q <= vld_rp;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_q    <= {16'd0, rp} * {16'd0, rp};
      qq_q    <= {16'd0, rq} * {16'd0, rq};
      tir_h_q <= rp_sb.tir;
    end
  end

  // Stage I: average, saturate, output register
  logic [32:0] sum;
  logic [16:0] avg;
  logic [15:0] refl_d, refl_q;
  logic        tir_q, vld_o_q;
  always_comb begin
    sum    = {1'b0, pp_q} + {1'b0, qq_q};
    avg    = sum[32:16];
    refl_d = (avg > {1'b0, fdr_pkg::OneQ15}) ? fdr_pkg::OneQ15 : avg[15:0];
    if (tir_h_q) refl_d = fdr_pkg::OneQ15;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_o_q <= 1'b0;
    else if (en) vld_o_q <= vld_h_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      refl_q <= refl_d;
      tir_q  <= tir_h_q;
    end
  end

  assign m_axis_tvalid_o   = vld_o_q;
  assign m_axis_tdata_o    = refl_q;
  assign m_axis_tuser_o[0] = tir_q;

  // Checks
  `FDR_ASSERT_IMPLY(a_tir_full, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o == fdr_pkg::OneQ15)
  `FDR_ASSERT_IMPLY(a_refl_range, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o <= fdr_pkg::OneQ15)
  `FDR_ASSERT_IMPLY(a_ratio_lockstep, clk_i, rst_ni, 1'b1, vld_rp == vld_rq)

endmodule

@@ src/fdr_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module fdr_sqrt #(
  parameter int unsigned VW   = 30,
  parameter int unsigned SB_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [VW-1:0]     v_i,
  input  logic [SB_W-1:0]   sb_i,
  output logic              vld_o,
  output logic [VW/2-1:0]   root_o,
  output logic [SB_W-1:0]   sb_o
);

  localparam int unsigned RW  = VW / 2;
  localparam int unsigned RMW = RW + 3;

  logic            vld_q  [RW];
  logic [RMW-1:0]  rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [VW-1:0]   v_q    [RW];
  logic [SB_W-1:0] sb_q   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            p_vld;
    logic [RMW-1:0]  p_rem;
    logic [RW-1:0]   p_root;
    logic [VW-1:0]   p_v;
    logic [SB_W-1:0] p_sb;
    logic [RMW-1:0]  sh;
    logic [RMW-1:0]  trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign p_vld  = vld_i;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_v    = v_i;
      assign p_sb   = sb_i;
    end else begin : g_next
      assign p_vld  = vld_q[k-1];
      assign p_rem  = rem_q[k-1];
      assign p_root = root_q[k-1];
      assign p_v    = v_q[k-1];
      assign p_sb   = sb_q[k-1];
    end

    // bring down the next bit pair, test against 4*root+1
    assign sh    = {p_rem[RMW-3:0], p_v[VW-1 -: 2]};
    assign trial = {1'b0, p_root, 2'b01};
    assign ge    = (sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= p_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (sh - trial) : sh;
        root_q[k] <= {p_root[RW-2:0], ge};
        v_q[k]    <= {p_v[VW-3:0], 2'b00};
        sb_q[k]   <= p_sb;
      end
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];
  assign sb_o   = sb_q[RW-1];

endmodule

@@ src/fdr_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Needs r0 < den; gives floor(({r0, lo}) / den) over QW quotient bits.
module fdr_div #(
  parameter int unsigned DW   = 16,
  parameter int unsigned QW   = 14,
  parameter int unsigned SB_W = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [DW-1:0]   r0_i,
  input  logic [QW-1:0]   lo_i,
  input  logic [DW-1:0]   den_i,
  input  logic [SB_W-1:0] sb_i,
  output logic            vld_o,
  output logic [QW-1:0]   quo_o,
  output logic [SB_W-1:0] sb_o
);

  logic            vld_q [QW];
  logic [DW-1:0]   rem_q [QW];
  logic [QW-1:0]   quo_q [QW];
  logic [QW-1:0]   lo_q  [QW];
  logic [DW-1:0]   den_q [QW];
  logic [SB_W-1:0] sb_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic            p_vld;
    logic [DW-1:0]   p_rem;
    logic [QW-1:0]   p_quo;
    logic [QW-1:0]   p_lo;
    logic [DW-1:0]   p_den;
    logic [SB_W-1:0] p_sb;
    logic [DW:0]     sh;
    logic [DW:0]     diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign p_vld = vld_i;
      assign p_rem = r0_i;
      assign p_quo = '0;
      assign p_lo  = lo_i;
      assign p_den = den_i;
      assign p_sb  = sb_i;
    end else begin : g_next
      assign p_vld = vld_q[k-1];
      assign p_rem = rem_q[k-1];
      assign p_quo = quo_q[k-1];
      assign p_lo  = lo_q[k-1];
      assign p_den = den_q[k-1];
      assign p_sb  = sb_q[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign sh   = {p_rem, p_lo[QW-1]};
    assign diff = sh - {1'b0, p_den};
    assign ge   = (sh >= {1'b0, p_den});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= p_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DW-1:0] : sh[DW-1:0];
        quo_q[k] <= {p_quo[QW-2:0], ge};
        lo_q[k]  <= {p_lo[QW-2:0], 1'b0};
        den_q[k] <= p_den;
        sb_q[k]  <= p_sb;
      end
    end
  end

  assign vld_o = vld_q[QW-1];
  assign quo_o = quo_q[QW-1];
  assign sb_o  = sb_q[QW-1];

endmodule

@@ tb/fresnel_checker.sv @@
`timescale 1ns / 1ps
module fresnel_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [15:0] s_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [15:0] m_data_i,
  input  logic [0:0]  m_user_i,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          tir_seen_o,
  output int          refl_seen_o
);

  typedef struct packed {
    logic [15:0] refl;
    logic        tir;
  } refl_exp_t;

  refl_exp_t   refl_q[$];
  logic [15:0] eta_out_q, eta_in_q;

  // Bitwise integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned amp_ratio(longint unsigned x, longint unsigned y);
    longint unsigned den, num;
    den = x + y;
    num = (x >= y) ? x - y : y - x;
    if (den == 0) return 32768;
    return (num * 32768) / den;
  endfunction

  function automatic refl_exp_t fresnel_predict(logic signed [15:0] cos_in,
                                                logic [15:0] eo, logic [15:0] ein);
    int              cs;
    longint unsigned c, ei, et, si, st, ct, p, q, r;
    refl_exp_t       res;
    cs = cos_in;
    if (cs > 16384) cs = 16384;
    if (cs < -16384) cs = -16384;
    c  = (cs < 0) ? -cs : cs;
    ei = (cs > 0) ? eo : ein;
    et = (cs > 0) ? ein : eo;
    si = int_sqrt((64'd1 << 28) - c * c);
    res.refl = fdr_pkg::OneQ15;
    res.tir  = 1'b1;
    if (et == 0) return res;
    st = (ei * si) / et;
    if (st >= 16384) return res;
    ct = int_sqrt((64'd1 << 28) - st * st);
    p = amp_ratio(et * c, ei * ct);
    q = amp_ratio(ei * c, et * ct);
    r = (p * p + q * q) >> 16;
    if (r > 32768) r = 32768;
    res.refl = r[15:0];
    res.tir  = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    refl_exp_t e;
    if (!rst_ni) begin
      eta_out_q <= fdr_pkg::EtaOutsideRst;
      eta_in_q  <= fdr_pkg::EtaInsideRst;
      refl_q.delete();
      fail_cnt_o  = 0;
      pending_o   = 0;
      tir_seen_o  = 0;
      refl_seen_o = 0;
    end else begin
      // Output transaction
      if (m_valid_i && m_ready_i) begin
        if (refl_q.size() == 0) begin
          report_mismatch("unexpected result", m_data_i, -1);
        end else begin
          e = refl_q.pop_front();
          if (m_data_i !== e.refl) report_mismatch("reflectance", m_data_i, e.refl);
          if (m_user_i[0] !== e.tir) report_mismatch("total_internal", m_user_i, e.tir);
          if (e.tir) tir_seen_o++;
          else refl_seen_o++;
        end
      end
      // Input transaction
      if (s_valid_i && s_ready_i)
        refl_q.push_back(fresnel_predict(s_data_i, eta_out_q, eta_in_q));
      pending_o = refl_q.size();
      // Register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == fdr_pkg::CFG_ETA_OUTSIDE) eta_out_q <= cfg_data_i;
        else eta_in_q <= cfg_data_i;
      end
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

  localparam int Latency = 67;

  logic        clk_i, rst_ni;
  logic        s_valid, s_ready, m_valid, m_ready;
  logic [15:0] s_data, m_data;
  logic [0:0]  m_user;
  logic        cfg_we;
  logic [0:0]  cfg_idx;
  logic [15:0] cfg_data;
  int          fail_cnt, pending, tir_seen, refl_seen, n_items;

  fresnel_dielectric_reflectance_top u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  fresnel_checker u_chk (
    .clk_i, .rst_ni,
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data), .m_user_i(m_user),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_cnt_o(fail_cnt), .pending_o(pending),
    .tir_seen_o(tir_seen), .refl_seen_o(refl_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random stall per result, with quiet stretches
  initial begin
    int gap;
    m_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if ((n_items / 200) % 3 == 1) gap = 0;
      m_ready = 1'b0;
      repeat (gap) @(negedge clk_i);
      m_ready = 1'b1;
      do @(posedge clk_i); while (!m_valid);
    end
  end

  task automatic write_reg(fdr_pkg::cfg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk_i);
    cfg_we   = 1'b0;
  endtask

  // One cosine transaction, preceded by a random gap unless no_gap is set
  task automatic send_cos(logic [15:0] cos_v, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_data  = cos_v;
    do @(posedge clk_i); while (!s_ready);
    @(negedge clk_i);
    n_items++;
  endtask

  task automatic drain();
    s_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 5) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_cos();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom());
      1:       return 16'($urandom_range(0, 40));
      2:       return 16'(16384 - $urandom_range(0, 40));
      3:       return 16'(-$urandom_range(0, 16384));
      default: return 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  initial begin
    logic [15:0] directed [] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h4000, 16'hC000,
                                 16'h4001, 16'hBFFF, 16'h7FFF, 16'h8000, 16'h2000,
                                 16'hE000, 16'h5555, 16'hAAAA, 16'h3FFF, 16'hC001};
    logic [15:0] etas [] = '{16'd4096, 16'd6144, 16'd1, 16'hFFFF, 16'd5461,
                             16'd4000, 16'd10240, 16'd4097};
    n_items  = 0;
    rst_ni   = 1'b0;
    s_valid  = 1'b0;
    s_data   = '0;
    cfg_we   = 1'b0;
    cfg_idx  = fdr_pkg::CFG_ETA_OUTSIDE;
    cfg_data = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset indices, then index extremes
    foreach (directed[i]) send_cos(directed[i], (i % 2) == 1);
    drain();
    write_reg(fdr_pkg::CFG_ETA_OUTSIDE, 16'hFFFF);
    write_reg(fdr_pkg::CFG_ETA_INSIDE, 16'd1);
    for (int i = 0; i < 5; i++) send_cos(directed[i], 1'b0);
    drain();

    // Random phases, each with its own index pair
    for (int ph = 0; ph < 16; ph++) begin
      write_reg(fdr_pkg::CFG_ETA_OUTSIDE,
                ($urandom_range(0, 1) != 0) ? etas[$urandom_range(0, 7)]
                                            : 16'($urandom_range(1, 65535)));
      write_reg(fdr_pkg::CFG_ETA_INSIDE,
                ($urandom_range(0, 1) != 0) ? etas[$urandom_range(0, 7)]
                                            : 16'($urandom_range(1, 65535)));
      for (int i = 0; i < 95; i++) send_cos(rand_cos(), $urandom_range(0, 2) == 0);
      drain();
    end

    $display("covered %0d cosines over 18 index settings", n_items);
    $display("results: %0d total internal, %0d partial reflections", tir_seen, refl_seen);
    if (fail_cnt == 0) begin
      $display("PASS fresnel_dielectric_reflectance_top");
    end else begin
      $display("FAIL fresnel_dielectric_reflectance_top");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL fresnel_dielectric_reflectance_top");
    $finish;
  end

endmodule
